[hw/rtl/tse_pkg.sv]
// shared types and constants of the table search engine
package tse_pkg;

    localparam int VALUE_W    = 32;
    localparam int ENTRY_IDX_W = 5;
    localparam int POS_W      = 6;
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    // signed bound width: holds -1 up to the largest length
    localparam int BOUND_W    = 7;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LBOUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [ENTRY_IDX_W-1:0]    entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] search_key;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN,
        S_BPROBE,
        S_BCMP,
        S_LBREAD,
        S_LBCHK
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_PTR_NEXT,
        RD_MID,
        RD_HI
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_LIN_MISS,
        RES_LIN_HIT,
        RES_EXACT,
        RES_LBOUND
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     init;
        logic     lin_adv;
        logic     bin_probe;
        logic     bin_update;
        logic     finish;
        rd_sel_t  rd_sel;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_linear;
        logic is_exact;
        logic lin_end;
        logic key_eq;
        logic exact_done;
        logic lb_done;
    } dp_stat_t;

endpackage

[hw/rtl/tse_ctrl.sv]
// search sequencer: state machine that drives the datapath
module tse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  tse_pkg::dp_stat_t stat,
    output tse_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import tse_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && func == FUNC_SEARCH)
                begin
                    if (stat.is_linear)
                        state_next = S_LIN;
                    else
                        state_next = S_BPROBE;
                end
            end
            S_LIN:
            begin
                if (stat.lin_end || stat.key_eq)
                    state_next = S_IDLE;
            end
            S_BPROBE:
                state_next = S_BCMP;
            S_BCMP:
            begin
                if (stat.is_exact)
                begin
                    state_next = stat.exact_done ? S_IDLE : S_BPROBE;
                end
                else
                begin
                    state_next = stat.lb_done ? S_LBREAD : S_BPROBE;
                end
            end
            S_LBREAD:
                state_next = S_LBCHK;
            S_LBCHK:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '{load: 1'b0, init: 1'b0, lin_adv: 1'b0, bin_probe: 1'b0,
                bin_update: 1'b0, finish: 1'b0, rd_sel: RD_ZERO,
                res_sel: RES_LIN_MISS};
        unique case (state_reg)
            S_IDLE:
            begin
                // address zero is read here so a linear scan starts at once
                cmd.rd_sel = RD_ZERO;
                cmd.load   = accept && func == FUNC_LOAD;
                cmd.init   = accept && func == FUNC_SEARCH;
            end
            S_LIN:
            begin
                cmd.rd_sel = RD_PTR_NEXT;
                if (stat.lin_end)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_LIN_MISS;
                end
                else if (stat.key_eq)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_LIN_HIT;
                end
                else
                begin
                    cmd.lin_adv = 1'b1;
                end
            end
            S_BPROBE:
            begin
                cmd.rd_sel    = RD_MID;
                cmd.bin_probe = 1'b1;
            end
            S_BCMP:
            begin
                cmd.bin_update = 1'b1;
                if (stat.is_exact && stat.exact_done)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_EXACT;
                end
            end
            S_LBREAD:
            begin
                cmd.rd_sel = RD_HI;
            end
            S_LBCHK:
            begin
                cmd.finish  = 1'b1;
                cmd.res_sel = RES_LBOUND;
            end
            default:
            begin
                cmd.rd_sel = RD_ZERO;
            end
        endcase
    end

endmodule

[hw/rtl/tse_datapath.sv]
// table memory, config registers, bounds, compare and result registers
module tse_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tse_pkg::request_t                 request,
    input  logic                              cfg_wr_en,
    input  logic [tse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  tse_pkg::dp_cmd_t                  cmd,
    output tse_pkg::dp_stat_t                 stat,
    output tse_pkg::result_t                  result,
    output logic                              done
);
    import tse_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int N_MAX = (TABLE_DEPTH < 63) ? TABLE_DEPTH : 63;

    logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic [POS_W-1:0]          rd_idx;
    logic                      wr_ok;

    logic [MODE_W-1:0]         search_mode_reg;
    logic [LEN_W-1:0]          table_length_reg;
    logic [POS_W-1:0]          n_eff;

    logic signed [VALUE_W-1:0] key_reg;
    logic [POS_W-1:0]          n_reg;
    logic [POS_W-1:0]          ptr_reg;
    logic [POS_W-1:0]          ptr_next;
    logic signed [BOUND_W-1:0] lo_reg;
    logic signed [BOUND_W-1:0] lo_next;
    logic signed [BOUND_W-1:0] lo_upd;
    logic signed [BOUND_W-1:0] hi_reg;
    logic signed [BOUND_W-1:0] hi_next;
    logic signed [BOUND_W-1:0] hi_upd;
    logic [POS_W-1:0]          m_reg;
    logic [BOUND_W:0]          sum;
    logic [POS_W-1:0]          mid;
    logic signed [BOUND_W-1:0] m_ext;
    logic                      key_gt;
    logic                      key_eq;

    result_t                   result_reg;
    result_t                   result_next;
    logic                      done_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg  <= MODE_LINEAR;
            table_length_reg <= LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SEARCH_MODE:  search_mode_reg  <= cfg_data[MODE_W-1:0];
                REG_TABLE_LENGTH: table_length_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero length acts as one, oversize saturates to the depth
    always_comb
    begin
        if (table_length_reg == '0)
            n_eff = POS_W'(1);
        else if (32'(table_length_reg) > 32'(N_MAX))
            n_eff = POS_W'(N_MAX);
        else
            n_eff = table_length_reg;
    end

    // table memory, one write and one registered read per cycle
    assign wr_ok = 32'(request.entry_index) < 32'(TABLE_DEPTH);

    always_comb
    begin
        sum = {lo_reg[BOUND_W-1], lo_reg} + {hi_reg[BOUND_W-1], hi_reg};
        mid = sum[POS_W:1];
        case (cmd.rd_sel)
            RD_ZERO:     rd_idx = '0;
            RD_PTR_NEXT: rd_idx = ptr_reg + POS_W'(1);
            RD_MID:      rd_idx = mid;
            RD_HI:       rd_idx = hi_reg[POS_W-1:0];
            default:     rd_idx = '0;
        endcase
        rd_addr = AW'(rd_idx);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_ok)
            mem[AW'(request.entry_index)] <= request.entry_value;
        rd_data_reg <= mem[rd_addr];
    end

    // compare against the entry read last cycle
    assign key_gt = key_reg > rd_data_reg;
    assign key_eq = key_reg == rd_data_reg;
    assign m_ext  = $signed({1'b0, m_reg});

    // bounds after a binary compare, also used for the loop exit tests
    always_comb
    begin
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (key_gt)
            lo_upd = m_ext + BOUND_W'(1);
        else if (search_mode_reg == MODE_EXACT)
            hi_upd = m_ext - BOUND_W'(1);
        else
            hi_upd = m_ext;
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (cmd.init)
        begin
            ptr_next = '0;
            lo_next  = '0;
            hi_next  = $signed({1'b0, n_eff}) - BOUND_W'(1);
        end
        else if (cmd.lin_adv)
        begin
            ptr_next = ptr_reg + POS_W'(1);
        end
        else if (cmd.bin_update)
        begin
            lo_next = lo_upd;
            hi_next = hi_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            key_reg <= request.search_key;
            n_reg   <= n_eff;
        end
        if (cmd.bin_probe)
            m_reg <= mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
    end

    always_comb
    begin
        stat.is_linear  = (search_mode_reg != MODE_EXACT) &&
                          (search_mode_reg != MODE_LBOUND);
        stat.is_exact   = (search_mode_reg == MODE_EXACT);
        stat.lin_end    = (ptr_reg == n_reg);
        stat.key_eq     = key_eq;
        stat.exact_done = key_eq || (lo_upd > hi_upd);
        stat.lb_done    = !(lo_upd < hi_upd);
    end

    // result register and one-cycle strobe
    always_comb
    begin
        result_next = result_reg;
        if (cmd.finish)
        begin
            case (cmd.res_sel)
                RES_LIN_MISS: result_next = '{position: n_reg, found: 1'b0};
                RES_LIN_HIT:  result_next = '{position: ptr_reg, found: 1'b1};
                RES_EXACT:    result_next = '{position: m_reg, found: key_eq};
                RES_LBOUND:   result_next = '{position: hi_reg[POS_W-1:0],
                                              found: key_eq};
                default:      result_next = result_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[hw/rtl/table_search_engine_unit.sv]
// top level of the table search engine: sequencer plus datapath
//
// A load request (func 0) writes one table entry in the cycle it is taken and
// gives no result. A search request (func 1) gives one result on result,
// marked by done high for a single cycle; the receiver cannot stall it, so
// it must take every result as it comes. start is taken only while busy is
// low. The table has a single read port whose data is registered, so a linear
// search reads one entry per cycle and ends early on a hit. Each binary probe
// first reads the middle entry, then compares and updates the bounds; a lower
// bound search ends with a read of the entry at the final bound. Write the
// configuration registers only while busy is low and no result is pending.
module table_search_engine_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tse_pkg::request_t                 request,
    input  logic                              cfg_wr_en,
    input  logic [tse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output tse_pkg::result_t                  result
);
    import tse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (request.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tse_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result),
        .done      (done)
    );

endmodule

[bench/tb_table_search_engine_unit.sv]
`timescale 1ns / 1ps
// self-checking testbench of the table search engine: table loads and keyed searches
module tb_table_search_engine_unit;
    import tse_pkg::*;

    localparam int     TABLE_DEPTH   = 32;
    localparam int     ITEM_TARGET   = 950;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     IDLE_PERCENT  = 35;
    localparam longint TIMEOUT_NS    = 10_000_000;

    localparam logic [MODE_W-1:0]         MODE_SPARE = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX  = 32'sh7FFF_FFFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    request_t              request   = '0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  done;
    result_t               result;

    request_t                  pending_requests[$];
    result_t                   awaited_results[$];
    logic signed [VALUE_W-1:0] table_mirror[TABLE_DEPTH];
    logic signed [VALUE_W-1:0] staged_values[TABLE_DEPTH];
    logic [MODE_W-1:0]         mode_mirror    = MODE_LINEAR;
    logic [LEN_W-1:0]          length_mirror  = 6'd1;
    bit                        took_item      = 1'b0;
    bit                        steady_sender  = 1'b0;
    int                        items_queued   = 0;
    int                        mismatch_count = 0;

    table_search_engine_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // position and found flag the block should give for this key
    function automatic result_t lookup_position(logic signed [VALUE_W-1:0] key);
        int      span;
        int      lo;
        int      hi;
        int      mid;
        int      pos;
        result_t res;

        if (length_mirror == '0)
            span = 1;
        else if (int'(length_mirror) > TABLE_DEPTH)
            span = TABLE_DEPTH;
        else
            span = int'(length_mirror);
        lo  = 0;
        hi  = span - 1;
        mid = 0;
        if (mode_mirror == MODE_EXACT)
        begin
            do
            begin
                mid = (lo + hi) / 2;
                if (key > table_mirror[mid])
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end while (table_mirror[mid] != key && lo <= hi);
            pos = mid;
        end
        else if (mode_mirror == MODE_LBOUND)
        begin
            do
            begin
                mid = (lo + hi) / 2;
                if (key > table_mirror[mid])
                    lo = mid + 1;
                else
                    hi = mid;
            end while (lo < hi);
            pos = hi;
        end
        else
        begin
            // linear scan, the spare mode included
            pos = 0;
            while (pos < span && table_mirror[pos] != key)
                pos++;
        end
        res.position = POS_W'(pos);
        res.found    = (pos < span && table_mirror[pos] == key) ? 1'b1 : 1'b0;
        return res;
    endfunction

    // sender: holds an item until it is taken, may idle between items unless steady_sender is set
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_item))
        begin
            if (pending_requests.size() > 0
                && (steady_sender || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                start   <= 1'b1;
                request <= pending_requests.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;

        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with none awaited: position %0d found %0b",
                                              result.position, result.found));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.position !== want.position)
                        report_mismatch($sformatf("position %0d, wanted %0d",
                                                  result.position, want.position));
                    if (result.found !== want.found)
                        report_mismatch($sformatf("found %0b, wanted %0b at position %0d",
                                                  result.found, want.found, want.position));
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_SEARCH_MODE)
                    mode_mirror = cfg_data[MODE_W-1:0];
                else if (cfg_index == REG_TABLE_LENGTH)
                    length_mirror = cfg_data;
            end
            took_item = start && (busy == 1'b0);
            if (took_item)
            begin
                if (request.func == FUNC_LOAD)
                    table_mirror[request.entry_index] = request.entry_value;
                else
                    awaited_results.push_back(lookup_position(request.search_key));
            end
        end
    end

    task automatic queue_load(int idx, logic signed [VALUE_W-1:0] val);
        request_t req;

        req.func        = FUNC_LOAD;
        req.entry_index = ENTRY_IDX_W'(idx);
        req.entry_value = val;
        req.search_key  = $signed($urandom);
        pending_requests.push_back(req);
        staged_values[idx] = val;
        items_queued++;
    endtask

    task automatic queue_search(logic signed [VALUE_W-1:0] key);
        request_t req;

        req.func        = FUNC_SEARCH;
        req.entry_index = ENTRY_IDX_W'($urandom);
        req.entry_value = $signed($urandom);
        req.search_key  = key;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    // sender drained, every result in, then some slack for a trailing load
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || start || busy !== 1'b0
               || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // upper data bits are junk that the mode register drops
    task automatic set_mode(logic [MODE_W-1:0] mode);
        logic [CFG_DATA_W-MODE_W-1:0] junk;

        junk = (CFG_DATA_W-MODE_W)'($urandom);
        write_reg(REG_SEARCH_MODE, {junk, mode});
    endtask

    task automatic set_length(logic [LEN_W-1:0] len);
        write_reg(REG_TABLE_LENGTH, len);
    endtask

    task automatic run_phase(int phase_no);
        logic [MODE_W-1:0]         mode;
        logic [LEN_W-1:0]          len;
        int                        span;
        int                        step_max;
        int                        pick;
        int                        searches;
        int                        slot;
        bit                        ordered;
        longint                    acc;

        case (phase_no < 8 ? phase_no % 4 : int'($urandom_range(0, 3)))
            0:       mode = MODE_LINEAR;
            1:       mode = MODE_EXACT;
            2:       mode = MODE_LBOUND;
            default: mode = MODE_SPARE;
        endcase
        pick = $urandom_range(0, 99);
        if (phase_no == 0)
            len = 6'd63;
        else if (phase_no == 1)
            len = 6'd0;
        else if (phase_no == 2)
            len = LEN_W'(TABLE_DEPTH);
        else if (phase_no == 3)
            len = 6'd33;
        else if (pick < 50)
            len = LEN_W'($urandom_range(1, 8));
        else if (pick < 80)
            len = LEN_W'($urandom_range(9, TABLE_DEPTH));
        else if (pick < 90)
            len = LEN_W'(TABLE_DEPTH);
        else if (pick < 95)
            len = 6'd0;
        else
            len = LEN_W'($urandom_range(TABLE_DEPTH + 1, 63));
        if (len == '0)
            span = 1;
        else if (int'(len) > TABLE_DEPTH)
            span = TABLE_DEPTH;
        else
            span = int'(len);

        wait_quiet();
        steady_sender = (phase_no >= 6 && phase_no < 10);
        set_mode(mode);
        set_length(len);

        // mostly ascending tables so the binary modes go deep
        ordered = ($urandom_range(0, 99) < 75);
        case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 3;
            2:       step_max = 5000;
            default: step_max = 1 << 27;
        endcase
        if (step_max > 5000 || $urandom_range(0, 4) == 0)
            acc = longint'(VALUE_MIN) + longint'($urandom_range(0, 1 << 20));
        else
            acc = longint'($signed($urandom));
        for (int i = 0; i < span; i++)
        begin
            if (ordered)
            begin
                queue_load(i, VALUE_W'(acc));
                acc = acc + longint'($urandom_range(0, step_max));
                if (acc > longint'(VALUE_MAX))
                    acc = longint'(VALUE_MAX);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                queue_load(i, $signed($urandom));
            end
            else
            begin
                queue_load(i, $signed(VALUE_W'($urandom_range(0, 6))) - 3);
            end
        end
        if (span < TABLE_DEPTH && $urandom_range(0, 1) == 0)
            queue_load($urandom_range(span, TABLE_DEPTH - 1), $signed($urandom));

        searches = $urandom_range(12, 30);
        for (int s = 0; s < searches; s++)
        begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, span - 1);
            if (pick < 55)
                queue_search(staged_values[slot]);
            else if (pick < 70)
                queue_search(staged_values[slot] + (($urandom_range(0, 1) == 0) ? 1 : -1));
            else if (pick < 74)
                queue_search(VALUE_MIN);
            else if (pick < 78)
                queue_search(VALUE_MAX);
            else if (pick < 92)
                queue_search($signed($urandom));
            else
                queue_load($urandom_range(0, TABLE_DEPTH - 1), $signed($urandom));
        end
    endtask

    initial
    begin : stimulus
        int phase_no;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every entry gets a value before any search can read it
        for (int i = 0; i < TABLE_DEPTH; i++)
            queue_load(i, VALUE_W'(i * 1000 - 16000));

        // reset settings: linear over a single entry
        queue_search(-32'sd16000);
        queue_search(VALUE_MAX);
        queue_load(0, VALUE_MIN);
        queue_load(1, -1);
        queue_load(2, 0);
        queue_load(3, VALUE_MAX);
        wait_quiet();
        set_length(6'd4);
        queue_search(0);
        queue_search(5);
        queue_search(VALUE_MIN);
        wait_quiet();
        set_mode(MODE_EXACT);
        queue_search(VALUE_MAX);
        queue_search(VALUE_MIN);
        queue_search(7);
        wait_quiet();
        set_mode(MODE_LBOUND);
        queue_search(1);
        queue_search(VALUE_MIN);
        queue_search(VALUE_MAX);
        wait_quiet();
        // key above every entry in use clamps to the last one
        set_length(6'd3);
        queue_search(VALUE_MAX);
        wait_quiet();
        set_mode(MODE_SPARE);
        queue_search(-1);
        wait_quiet();
        // zero length acts as one entry
        set_mode(MODE_EXACT);
        set_length(6'd0);
        queue_search(VALUE_MIN);
        queue_search(-1);

        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        wait_quiet();

        if (mismatch_count == 0)
            $display("tb_table_search_engine_unit: PASS");
        else
            $display("tb_table_search_engine_unit: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_table_search_engine_unit: FAIL");
        $finish;
    end

endmodule

[table_search_engine_unit.f]
hw/rtl/tse_pkg.sv
hw/rtl/tse_ctrl.sv
hw/rtl/tse_datapath.sv
hw/rtl/table_search_engine_unit.sv
bench/tb_table_search_engine_unit.sv
